// ===== src/wpsp_pkg.sv =====
package wpsp_pkg;

    // Fixed field widths.
    localparam int WORD_W       = 32;
    localparam int CFG_W        = 64;
    localparam int DIM_W        = 14;
    localparam int CFG_IDX_W    = 3;
    localparam int DEFAULT_FRAC = 16;

    // Quotient bits kept by the divider; anything at or above 2^QUO_W saturates.
    localparam int QUO_W = 33;

    // Reset viewport.
    localparam logic [DIM_W-1:0] VIEW_W_RST = DIM_W'(1920);
    localparam logic [DIM_W-1:0] VIEW_H_RST = DIM_W'(1080);

    // Saturation limits of a screen coordinate.
    localparam logic [WORD_W-1:0] SAT_POS = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] SAT_NEG = {1'b1, {(WORD_W-1){1'b0}}};

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COL_X_AB  = 3'd0,
        CFG_COL_X_CD  = 3'd1,
        CFG_COL_Y_AB  = 3'd2,
        CFG_COL_Y_CD  = 3'd3,
        CFG_COL_W_AB  = 3'd4,
        CFG_COL_W_CD  = 3'd5,
        CFG_VIEW_W    = 3'd6,
        CFG_VIEW_H    = 3'd7
    } t_cfg_idx;

    // Flags that travel beside a coordinate through the divider.
    typedef struct packed {
        logic neg;   // numerator was negative
        logic keep;  // point visible, otherwise the result is forced to zero
        logic ovf;   // quotient at least 2^QUO_W
    } t_side;

endpackage

// ===== src/wpsp_point_if.sv =====
interface wpsp_point_if;
    logic                              valid;
    logic                              ready;
    logic signed [wpsp_pkg::WORD_W-1:0] world_x;
    logic signed [wpsp_pkg::WORD_W-1:0] world_y;
    logic signed [wpsp_pkg::WORD_W-1:0] world_z;

    modport source (output valid, world_x, world_y, world_z, input ready);
    modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

// ===== src/wpsp_screen_if.sv =====
interface wpsp_screen_if;
    logic                              valid;
    logic                              ready;
    logic                              visible;
    logic signed [wpsp_pkg::WORD_W-1:0] screen_x;
    logic signed [wpsp_pkg::WORD_W-1:0] screen_y;

    modport source (output valid, visible, screen_x, screen_y, input ready);
    modport sink   (input valid, visible, screen_x, screen_y, output ready);
endinterface

// ===== src/wpsp_clip.sv =====
module wpsp_clip #(
    parameter int FRAC   = wpsp_pkg::DEFAULT_FRAC,
    parameter int CLIP_W = 67 - FRAC
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [wpsp_pkg::WORD_W-1:0] i_x,
    input  logic signed [wpsp_pkg::WORD_W-1:0] i_y,
    input  logic signed [wpsp_pkg::WORD_W-1:0] i_z,
    input  logic [2:0][wpsp_pkg::CFG_W-1:0]    i_ab,
    input  logic [2:0][wpsp_pkg::CFG_W-1:0]    i_cd,
    output logic                               o_valid,
    output logic signed [2:0][CLIP_W-1:0]      o_clip
);

    localparam int W  = wpsp_pkg::WORD_W;
    localparam int PW = 2 * W;
    localparam int SW = PW + 2;

    logic                        r_vld1;
    logic signed [PW-1:0]        r_prod [3][3];

    // Stage one: nine signed products, one multiplier each.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_row
        logic signed [W-1:0] wx, wy, wz, off;
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] shr;

        assign wx  = i_ab[g][W-1:0];
        assign wy  = i_ab[g][PW-1:W];
        assign wz  = i_cd[g][W-1:0];
        assign off = i_cd[g][PW-1:W];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_prod[g][0] <= PW'(i_x) * PW'(wx);
                r_prod[g][1] <= PW'(i_y) * PW'(wy);
                r_prod[g][2] <= PW'(i_z) * PW'(wz);
            end
        end

        // Stage two: exact sum, floor to whole fixed point, add the offset.
        assign sum = SW'(r_prod[g][0]) + SW'(r_prod[g][1]) + SW'(r_prod[g][2]);
        assign shr = sum >>> FRAC;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                o_clip[g] <= CLIP_W'(shr) + CLIP_W'(off);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_vld1;
        end
    end

endmodule

// ===== src/wpsp_div.sv =====
module wpsp_div #(
    parameter int D_W = 51,
    parameter int RW  = 84
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [RW-1:0]                     i_rem,
    input  logic [D_W-1:0]                    i_div,
    input  wpsp_pkg::t_side                   i_side,
    output logic                              o_valid,
    output logic [wpsp_pkg::QUO_W-1:0]        o_quo,
    output wpsp_pkg::t_side                   o_side
);

    localparam int QW = wpsp_pkg::QUO_W;

    logic                 r_vld  [QW];
    logic [RW-1:0]        r_rem  [QW];
    logic [D_W-1:0]       r_div  [QW];
    logic [QW-1:0]        r_quo  [QW];
    wpsp_pkg::t_side      r_side [QW];

    // One quotient bit per stage, most significant first.
    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic                 vld_in;
        logic [RW-1:0]        rem_in;
        logic [D_W-1:0]       div_in;
        logic [QW-1:0]        quo_in;
        wpsp_pkg::t_side      side_in;
        logic [RW-1:0]        trial;
        logic                 ge;

        if (s == 0) begin : g_first
            assign vld_in  = i_valid;
            assign rem_in  = i_rem;
            assign div_in  = i_div;
            assign quo_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[s-1];
            assign rem_in  = r_rem[s-1];
            assign div_in  = r_div[s-1];
            assign quo_in  = r_quo[s-1];
            assign side_in = r_side[s-1];
        end

        assign trial = RW'(div_in) << (QW - 1 - s);
        assign ge    = (rem_in >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= ge ? rem_in - trial : rem_in;
                r_div[s]  <= div_in;
                r_quo[s]  <= {quo_in[QW-2:0], ge};
                r_side[s] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ===== src/wpsp_lane.sv =====
module wpsp_lane #(
    parameter int FRAC   = wpsp_pkg::DEFAULT_FRAC,
    parameter int CLIP_W = 67 - FRAC
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic                               i_keep,
    input  logic signed [CLIP_W:0]             i_num,
    input  logic [CLIP_W-1:0]                  i_cw,
    input  logic [wpsp_pkg::DIM_W-1:0]         i_dim,
    output logic                               o_valid,
    output logic [wpsp_pkg::WORD_W-1:0]        o_coord
);

    localparam int QW     = wpsp_pkg::QUO_W;
    localparam int W      = wpsp_pkg::WORD_W;
    localparam int NUM_W  = CLIP_W + 1;
    localparam int PROD_W = NUM_W + wpsp_pkg::DIM_W;
    localparam int N_W    = PROD_W + FRAC + 1;
    localparam int D_W    = CLIP_W;
    localparam int RW     = (N_W > D_W + QW) ? N_W : D_W + QW;

    logic                  r_vld1, r_vld2, r_vld3;
    logic [PROD_W-1:0]     r_prod;
    logic [CLIP_W-1:0]     r_cw1;
    logic [N_W-1:0]        r_n;
    logic [D_W-1:0]        r_d2, r_d3;
    logic [RW-1:0]         r_rem;
    wpsp_pkg::t_side       r_side1, r_side2, r_side3;

    logic                  neg;
    logic [NUM_W-1:0]      mag;
    logic                  ovf;
    logic                  dv_valid;
    logic [QW-1:0]         dv_quo;
    wpsp_pkg::t_side       dv_side;
    logic                  sat;
    logic [W-1:0]          coord;

    // Stage one: magnitude of the numerator times the viewport dimension.
    assign neg = i_num[CLIP_W];
    assign mag = NUM_W'(neg ? -i_num : i_num);

    // Stage three: quotient too large for the divider.
    assign ovf = ({{QW{1'b0}}, r_n} >= {{(N_W - D_W){1'b0}}, r_d2, {QW{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod       <= PROD_W'(mag) * PROD_W'(i_dim);
            r_cw1        <= i_cw;
            r_side1.neg  <= neg;
            r_side1.keep <= i_keep;
            r_side1.ovf  <= 1'b0;
            // Stage two: scaled numerator plus half the divisor for rounding.
            r_n          <= (N_W'(r_prod) << FRAC) + N_W'(r_cw1);
            r_d2         <= {r_cw1[CLIP_W-2:0], 1'b0};
            r_side2      <= r_side1;
            r_rem        <= RW'(r_n);
            r_d3         <= r_d2;
            r_side3.neg  <= r_side2.neg;
            r_side3.keep <= r_side2.keep;
            r_side3.ovf  <= ovf;
        end
    end

    wpsp_div #(
        .D_W (D_W),
        .RW  (RW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_vld3),
        .i_rem   (r_rem),
        .i_div   (r_d3),
        .i_side  (r_side3),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // Final stage: saturate, apply the sign, zero when not visible.
    always_comb begin
        if (dv_side.neg) begin
            sat = dv_side.ovf || (dv_quo > QW'(wpsp_pkg::SAT_NEG));
        end else begin
            sat = dv_side.ovf || (dv_quo > QW'(wpsp_pkg::SAT_POS));
        end
        priority if (!dv_side.keep) begin
            coord = '0;
        end else if (sat) begin
            coord = dv_side.neg ? wpsp_pkg::SAT_NEG : wpsp_pkg::SAT_POS;
        end else if (dv_side.neg) begin
            coord = -dv_quo[W-1:0];
        end else begin
            coord = dv_quo[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_coord <= coord;
        end
    end

endmodule

// ===== src/world_point_screen_projector_top.sv =====
// Channel   Direction  Word contents
// i_pt      in         world_x, world_y, world_z (signed fixed point)
// o_scr     out        visible, screen_x, screen_y (signed fixed point)
// i_cfg_*   in         register write: enable, index, 64-bit data
//
// One word is accepted every cycle while the output is not stalled.
// The depth is set by the divider, which resolves one quotient bit per stage.
// A stalled output word freezes the whole pipeline; i_pt.ready is low only then.
// Reset is synchronous and active low; it clears the valid bits and the matrix registers.
module world_point_screen_projector_top #(
    parameter int COORD_FRAC_BITS = wpsp_pkg::DEFAULT_FRAC
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    wpsp_point_if.sink                           i_pt,
    wpsp_screen_if.source                        o_scr,
    input  logic                                 i_cfg_we,
    input  logic [wpsp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [wpsp_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int CLIP_W = 67 - COORD_FRAC_BITS;
    localparam int DIM_W  = wpsp_pkg::DIM_W;
    localparam logic signed [CLIP_W-1:0] THRESH =
        CLIP_W'(((64'sd1 <<< COORD_FRAC_BITS) + 64'sd500) / 64'sd1000);

    logic [2:0][wpsp_pkg::CFG_W-1:0] r_ab;
    logic [2:0][wpsp_pkg::CFG_W-1:0] r_cd;
    logic [DIM_W-1:0]                r_view_w;
    logic [DIM_W-1:0]                r_view_h;

    logic                            en;
    logic                            clip_vld;
    logic signed [2:0][CLIP_W-1:0]   clip;

    logic                            r_vld;
    logic                            r_vis;
    logic signed [CLIP_W:0]          r_num_x;
    logic signed [CLIP_W:0]          r_num_y;
    logic [CLIP_W-1:0]               r_cw;

    logic                            vx, vy;
    logic [wpsp_pkg::WORD_W-1:0]     sx, sy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ab     <= '0;
            r_cd     <= '0;
            r_view_w <= wpsp_pkg::VIEW_W_RST;
            r_view_h <= wpsp_pkg::VIEW_H_RST;
        end else if (i_cfg_we) begin
            unique case (wpsp_pkg::t_cfg_idx'(i_cfg_idx))
                wpsp_pkg::CFG_COL_X_AB: r_ab[0] <= i_cfg_data;
                wpsp_pkg::CFG_COL_X_CD: r_cd[0] <= i_cfg_data;
                wpsp_pkg::CFG_COL_Y_AB: r_ab[1] <= i_cfg_data;
                wpsp_pkg::CFG_COL_Y_CD: r_cd[1] <= i_cfg_data;
                wpsp_pkg::CFG_COL_W_AB: r_ab[2] <= i_cfg_data;
                wpsp_pkg::CFG_COL_W_CD: r_cd[2] <= i_cfg_data;
                wpsp_pkg::CFG_VIEW_W:   r_view_w <= i_cfg_data[DIM_W-1:0];
                wpsp_pkg::CFG_VIEW_H:   r_view_h <= i_cfg_data[DIM_W-1:0];
                default:                r_view_h <= r_view_h;
            endcase
        end
    end

    // The pipeline moves whenever the output word is empty or being taken.
    assign en         = !o_scr.valid || o_scr.ready;
    assign i_pt.ready = en;

    wpsp_clip #(
        .FRAC   (COORD_FRAC_BITS),
        .CLIP_W (CLIP_W)
    ) u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_pt.valid),
        .i_x     (i_pt.world_x),
        .i_y     (i_pt.world_y),
        .i_z     (i_pt.world_z),
        .i_ab    (r_ab),
        .i_cd    (r_cd),
        .o_valid (clip_vld),
        .o_clip  (clip)
    );

    // Visibility test and the two numerators (w + x, w - y).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= clip_vld;
        end
    end

    // An element of the packed clip array reads as unsigned, so its sign is restored here.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vis   <= ($signed(clip[2]) >= THRESH);
            r_num_x <= (CLIP_W + 1)'($signed(clip[2])) + (CLIP_W + 1)'($signed(clip[0]));
            r_num_y <= (CLIP_W + 1)'($signed(clip[2])) - (CLIP_W + 1)'($signed(clip[1]));
            r_cw    <= clip[2];
        end
    end

    wpsp_lane #(
        .FRAC   (COORD_FRAC_BITS),
        .CLIP_W (CLIP_W)
    ) u_lane_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vld),
        .i_keep  (r_vis),
        .i_num   (r_num_x),
        .i_cw    (r_cw),
        .i_dim   (r_view_w),
        .o_valid (vx),
        .o_coord (sx)
    );

    wpsp_lane #(
        .FRAC   (COORD_FRAC_BITS),
        .CLIP_W (CLIP_W)
    ) u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vld),
        .i_keep  (r_vis),
        .i_num   (r_num_y),
        .i_cw    (r_cw),
        .i_dim   (r_view_h),
        .o_valid (vy),
        .o_coord (sy)
    );

    // The output word is valid only when both lanes hold a valid coordinate.
    assign o_scr.valid    = vx && vy;
    assign o_scr.screen_x = sx;
    assign o_scr.screen_y = sy;

    // Visibility travels with the lanes as its own small delay line.
    localparam int LANE_LAT = wpsp_pkg::QUO_W + 4;
    logic [LANE_LAT-1:0] r_vis_dly;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vis_dly <= {r_vis_dly[LANE_LAT-2:0], r_vis};
        end
    end

    assign o_scr.visible = r_vis_dly[LANE_LAT-1];

endmodule

// ===== tb/tb_world_point_screen_projector_top.sv =====
`timescale 1ns / 1ps

// Expected screen word for one world point.
typedef struct {
    logic        visible;
    logic [31:0] screen_x;
    logic [31:0] screen_y;
} t_screen_word;

// Projection predictor with its own register copy and a queue of expected words.
class projection_scoreboard;
    localparam int FRAC = wpsp_pkg::DEFAULT_FRAC;
    localparam longint VIS_LIMIT = ((64'sd1 <<< FRAC) + 500) / 1000;

    logic [wpsp_pkg::CFG_W-1:0] matrix [6];
    logic [wpsp_pkg::DIM_W-1:0] view_w;
    logic [wpsp_pkg::DIM_W-1:0] view_h;
    t_screen_word     pending [$];
    int               mismatches;
    int               checked;
    int               visible_seen;

    function new();
        foreach (matrix[i]) matrix[i] = '0;
        view_w = wpsp_pkg::VIEW_W_RST;
        view_h = wpsp_pkg::VIEW_H_RST;
        mismatches = 0;
        checked = 0;
        visible_seen = 0;
    endfunction

    function void write_reg(wpsp_pkg::t_cfg_idx idx, logic [wpsp_pkg::CFG_W-1:0] data);
        if (idx == wpsp_pkg::CFG_VIEW_W) begin
            view_w = data[wpsp_pkg::DIM_W-1:0];
        end else if (idx == wpsp_pkg::CFG_VIEW_H) begin
            view_h = data[wpsp_pkg::DIM_W-1:0];
        end else begin
            matrix[idx] = data;
        end
    endfunction

    // One clip row, floored after the full-precision sum.
    function logic signed [63:0] clip_row(logic signed [31:0] x, logic signed [31:0] y,
                                          logic signed [31:0] z, logic [63:0] ab,
                                          logic [63:0] cd);
        logic signed [127:0] xs, ys, zs, wa, wb, wc, acc;
        logic signed [63:0]  offs;
        xs = x;
        ys = y;
        zs = z;
        wa = $signed(ab[31:0]);
        wb = $signed(ab[63:32]);
        wc = $signed(cd[31:0]);
        offs = $signed(cd[63:32]);
        acc = xs * wa + ys * wb + zs * wc;
        acc = acc >>> FRAC;
        return acc[63:0] + offs;
    endfunction

    // Scales num by dim / (2*cw), rounded half away from zero, then saturated.
    function logic [31:0] map_coord(logic signed [63:0] num, logic signed [63:0] cw,
                                    logic [wpsp_pkg::DIM_W-1:0] dim);
        logic        neg;
        logic [63:0] mag;
        logic [127:0] top, quo;
        neg = num < 0;
        mag = neg ? -num : num;
        top = ((128'(mag) * 128'(dim)) << FRAC) + 128'(cw);
        quo = top / (128'(cw) << 1);
        if (!neg) begin
            return (quo > 128'h7FFF_FFFF) ? wpsp_pkg::SAT_POS : quo[31:0];
        end
        if (quo > 128'h8000_0000) begin
            return wpsp_pkg::SAT_NEG;
        end
        return -quo[31:0];
    endfunction

    function void note_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
        t_screen_word w;
        logic signed [63:0] cx, cy, cw;
        cx = clip_row(x, y, z, matrix[wpsp_pkg::CFG_COL_X_AB],
                      matrix[wpsp_pkg::CFG_COL_X_CD]);
        cy = clip_row(x, y, z, matrix[wpsp_pkg::CFG_COL_Y_AB],
                      matrix[wpsp_pkg::CFG_COL_Y_CD]);
        cw = clip_row(x, y, z, matrix[wpsp_pkg::CFG_COL_W_AB],
                      matrix[wpsp_pkg::CFG_COL_W_CD]);
        if (cw < VIS_LIMIT) begin
            w = '{1'b0, 32'd0, 32'd0};
        end else begin
            w.visible  = 1'b1;
            w.screen_x = map_coord(cw + cx, cw, view_w);
            w.screen_y = map_coord(cw - cy, cw, view_h);
        end
        pending.push_back(w);
    endfunction

    function void check_word(logic vis, logic [31:0] sx, logic [31:0] sy);
        t_screen_word w;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected screen word: vis %0b x %h y %h", vis, sx, sy);
            end
            return;
        end
        w = pending.pop_front();
        checked++;
        if (vis) visible_seen++;
        if (vis !== w.visible || sx !== w.screen_x || sy !== w.screen_y) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("word %0d: expected vis %0b x %h y %h, got vis %0b x %h y %h",
                         checked, w.visible, w.screen_x, w.screen_y, vis, sx, sy);
            end
        end
    endfunction
endclass

module tb_world_point_screen_projector_top;
    localparam int LATENCY = 40;
    localparam logic [31:0] ONE = 32'h0001_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [wpsp_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [wpsp_pkg::CFG_W-1:0] i_cfg_data = '0;

    wpsp_point_if  pt_ch();
    wpsp_screen_if scr_ch();

    projection_scoreboard board = new();
    int tx_idle = 0;
    int rx_idle = 0;
    int points_sent = 0;

    world_point_screen_projector_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt       (pt_ch.sink),
        .o_scr      (scr_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        pt_ch.valid = 1'b0;
        pt_ch.world_x = '0;
        pt_ch.world_y = '0;
        pt_ch.world_z = '0;
        scr_ch.ready = 1'b0;
    end

    // Receiver stalls at random.
    always @(negedge i_clk) begin
        scr_ch.ready <= ($urandom_range(99) >= rx_idle);
    end

    // Every accepted screen word is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && scr_ch.valid && scr_ch.ready) begin
            board.check_word(scr_ch.visible, scr_ch.screen_x, scr_ch.screen_y);
        end
    end

    initial begin
        #5_000_000;
        $display("tb_world_point_screen_projector_top failed");
        $finish;
    end

    task automatic write_reg(wpsp_pkg::t_cfg_idx idx, logic [wpsp_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle) begin
            pt_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pt_ch.valid <= 1'b1;
        pt_ch.world_x <= x;
        pt_ch.world_y <= y;
        pt_ch.world_z <= z;
        do @(posedge i_clk); while (!pt_ch.ready);
        board.note_point(x, y, z);
        points_sent++;
    endtask

    // Lowers valid and waits until every expected word has come back.
    task automatic drain();
        @(negedge i_clk);
        pt_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // Simple perspective: clip x = x, clip y = y, clip w = z, plus small offsets.
    task automatic load_perspective(logic [31:0] xo, logic [31:0] yo, logic [31:0] wo);
        write_reg(wpsp_pkg::CFG_COL_X_AB, {32'd0, ONE});
        write_reg(wpsp_pkg::CFG_COL_X_CD, {xo, 32'd0});
        write_reg(wpsp_pkg::CFG_COL_Y_AB, {ONE, 32'd0});
        write_reg(wpsp_pkg::CFG_COL_Y_CD, {yo, 32'd0});
        write_reg(wpsp_pkg::CFG_COL_W_AB, 64'd0);
        write_reg(wpsp_pkg::CFG_COL_W_CD, {wo, ONE});
    endtask

    // Mostly points in front of the camera, the rest raw noise.
    task automatic random_points(int count);
        logic [31:0] x, y, z;
        int depth;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 70) begin
                depth = $urandom_range(1 << 22, 1);
                z = depth;
                x = $urandom_range(2 * depth) - depth;
                y = $urandom_range(2 * depth) - depth;
                if ($urandom_range(9) == 0) x = x <<< $urandom_range(6);
            end else begin
                x = $urandom;
                y = $urandom;
                z = $urandom;
            end
            send_point(x, y, z);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset matrix is all zero, so every point is behind the camera.
        send_point(32'h7FFF_FFFF, 32'h8000_0000, ONE);
        drain();

        // Directed points with the reset viewport.
        load_perspective(32'd0, 32'd0, 32'd0);
        send_point(32'd0, 32'd0, ONE);
        send_point(32'd0, 32'd0, 32'd0);
        send_point(32'd0, 32'd0, 32'd66);
        send_point(32'd0, 32'd0, 32'd65);
        send_point(32'd33, 32'hFFFF_FFDF, 32'd66);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd66);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'd66);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(ONE, 32'hFFFF_0000, ONE);
        send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000);
        send_point(32'hFFFE_0000, 32'h0003_0000, ONE);
        drain();

        // Zero and widest viewports, perspective with offsets.
        write_reg(wpsp_pkg::CFG_VIEW_W, 64'd16383);
        write_reg(wpsp_pkg::CFG_VIEW_H, 64'd0);
        load_perspective(32'h0000_4000, 32'hFFFF_C000, 32'h0000_1000);
        send_point(ONE, ONE, ONE);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, ONE);
        tx_idle = 37;
        rx_idle = 60;
        random_points(210);
        drain();

        // Arbitrary matrix terms with 8192 and 1 pixel viewports.
        write_reg(wpsp_pkg::CFG_VIEW_W, 64'd1);
        write_reg(wpsp_pkg::CFG_VIEW_H, 64'd8192);
        for (int r = 0; r < 6; r++) begin
            write_reg(wpsp_pkg::t_cfg_idx'(r), {$urandom, $urandom});
        end
        tx_idle = 60;
        rx_idle = 37;
        random_points(100);
        // Pause the sender until the pipeline is empty.
        drain();
        random_points(110);
        drain();

        // Ordinary screen with random register bits left in the upper viewport field.
        write_reg(wpsp_pkg::CFG_VIEW_W, {$urandom, $urandom} & ~64'h3FFF | 64'd640);
        write_reg(wpsp_pkg::CFG_VIEW_H, 64'd480);
        load_perspective($urandom_range(255), $urandom_range(255), $urandom_range(255));
        tx_idle = 0;
        rx_idle = 0;
        random_points(210);
        drain();

        $display("Sent %0d world points over four register settings;", points_sent);
        $display("%0d words checked, %0d visible.", board.checked, board.visible_seen);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("tb_world_point_screen_projector_top passed");
        end else begin
            $display("%0d mismatches, %0d words outstanding.",
                     board.mismatches, board.pending.size());
            $display("tb_world_point_screen_projector_top failed");
        end
        $finish;
    end
endmodule
